// File: rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// Keyed substitution table package
// Transfer types, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kst_pkg;

	// Operation codes carried in the func field.
	localparam logic [2:0] FN_LOOKUP   = 3'd0;
	localparam logic [2:0] FN_REGISTER = 3'd1;
	localparam logic [2:0] FN_LOAD     = 3'd2;
	localparam logic [2:0] FN_DEL_ID   = 3'd3;
	localparam logic [2:0] FN_DEL_CODE = 3'd4;
	localparam logic [2:0] FN_CLEAR    = 3'd5;
	localparam logic [2:0] FN_QUERY    = 3'd6;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NO_LAST = 2'd2;

	typedef struct packed {
		logic [2:0]        func;
		logic [15:0]       owner_id;
		logic [15:0]       code_key;
		logic [7:0]        entry_type;
		logic signed [3:0] hazard_index;
		logic signed [3:0] segment_index;
		logic [2:0]        slot_index;
		logic [15:0]       slot_code;
		logic [7:0]        slot_volume;
	} req_t;

	typedef struct packed {
		logic signed [16:0] result_code;
		logic [7:0]         noise_volume;
		logic               matched;
		logic               any_registered;
		logic [1:0]         status;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // capture the accepted request and restart the scan
		logic scan;     // walk the entry table
		logic clr_step; // write one zero row of the slot store
		logic exec;     // apply the operation and form the result
		logic push;     // move the result into the output register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;
		logic scan_done;
		logic is_lookup;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/keyed_substitution_table.sv
// ----------------------------------------------------------------------------
// Keyed substitution table
// Sound-code substitution table with lookup, registration, slot loading,
// deletion, clear-all and occupancy query operations.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result
// transfer for each. Lookup, register and both delete operations walk the
// entry table one entry per cycle through a single read port of the entry
// store; a lookup then makes one further read of the slot store before the
// result is formed and moved into the output register. Slot load, clear-all,
// query and the unused function code skip the scan. A finished result
// sits in the output register, so a new request is taken while the previous
// result still waits to be collected. After reset every word of the slot
// store, the next power of two at or above ENTRIES times the next power of
// two at or above SLOTS words (128 for the default sizes), is swept to zero
// one word per cycle, and no request is accepted during that sweep. Free
// entries never match; a lookup miss hands back the key masked to twelve
// bits, and a negative slot index gives a code of minus one with zero
// volume. Slot indexes beyond the slot count wrap around.
// ----------------------------------------------------------------------------
module keyed_substitution_table #(
	parameter int ENTRIES = 16,
	parameter int SLOTS   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  kst_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kst_pkg::rsp_t rsp_data
);

	// The controller sequences each operation; the datapath holds every
	// store, the scan compare stage and the output register.
	kst_pkg::cmd_t cmd;
	kst_pkg::sts_t sts;

	kst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (req_data.func),
		.cmd       (cmd),
		.sts       (sts)
	);

	kst_dp #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// File: rtl/kst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/kst_ctrl.sv
// ----------------------------------------------------------------------------
// Keyed substitution table controller
// Sequences the start-up clearing pass and the steps of each operation.
// ----------------------------------------------------------------------------
module kst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        func,
	output kst_pkg::cmd_t     cmd,
	input  kst_pkg::sts_t     sts
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_FETCH = 6'b001000,
		S_EXEC  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   needs_scan;

	assign needs_scan = (func == kst_pkg::FN_LOOKUP) || (func == kst_pkg::FN_REGISTER) ||
		(func == kst_pkg::FN_DEL_ID) || (func == kst_pkg::FN_DEL_CODE);

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = needs_scan ? S_SCAN : S_EXEC;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.is_lookup ? S_FETCH : S_EXEC;
				end
			end
			S_FETCH: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/kst_dp.sv
// ----------------------------------------------------------------------------
// Keyed substitution table datapath
// Entry and slot stores, the scan compare stage, valid bookkeeping and the
// output register.
// ----------------------------------------------------------------------------
module kst_dp #(
	parameter int ENTRIES = 16,
	parameter int SLOTS   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  kst_pkg::cmd_t cmd,
	output kst_pkg::sts_t sts,
	input  kst_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kst_pkg::rsp_t rsp_data
);

	localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int SAW = IW + SW;

	typedef struct packed {
		logic [15:0] owner;
		logic [15:0] key;
		logic        by_hazard;
	} entry_t;

	typedef struct packed {
		logic [15:0] code;
		logic [7:0]  volume;
	} slot_t;

	// Wraps a small non-negative index into the slot range.
	function automatic logic [SW-1:0] slot_wrap(input logic [2:0] v);
		logic [4:0] r;
		r = {2'b00, v};
		for (int k = 0; k < 8; k++) begin
			if (r >= 5'(SLOTS)) begin
				r = r - 5'(SLOTS);
			end
		end
		return r[SW-1:0];
	endfunction

	kst_pkg::req_t item_q;
	kst_pkg::rsp_t res_d, res_q, rsp_q, out_d;
	logic          rsp_valid_q;

	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_cnt_q;
	logic               cmp_v_s1;
	logic [IW-1:0]      cmp_idx_s1;
	logic               hit_q, hit_haz_q, free_q, last_ok_q;
	logic [IW-1:0]      hit_idx_q, free_idx_q, last_q;
	logic [SAW-1:0]     clr_cnt_q;

	entry_t         ent_wdata, ent_rdata;
	logic           ent_we;
	slot_t          slot_wdata, slot_rdata;
	logic           slot_we;
	logic [SAW-1:0] slot_waddr, slot_raddr;

	logic              fn_lookup, fn_reg, fn_load, fn_del_id, fn_del_code, fn_clear;
	logic              cur_valid, id_eq, key_eq;
	logic              drop, hit_now, free_now, claim, load_ok, issue;
	logic signed [3:0] sel_ix;

	assign fn_lookup   = (item_q.func == kst_pkg::FN_LOOKUP);
	assign fn_reg      = (item_q.func == kst_pkg::FN_REGISTER);
	assign fn_load     = (item_q.func == kst_pkg::FN_LOAD);
	assign fn_del_id   = (item_q.func == kst_pkg::FN_DEL_ID);
	assign fn_del_code = (item_q.func == kst_pkg::FN_DEL_CODE);
	assign fn_clear    = (item_q.func == kst_pkg::FN_CLEAR);

	// Scan compare stage: works on the entry read in the previous cycle.
	assign issue     = cmd.scan && (rd_cnt_q < CW'(ENTRIES));
	assign cur_valid = valid_q[cmp_idx_s1];
	assign id_eq     = (ent_rdata.owner == item_q.owner_id);
	assign key_eq    = (ent_rdata.key == item_q.code_key);

	assign drop = cmp_v_s1 && cur_valid && id_eq &&
		(fn_del_id || ((fn_reg || fn_del_code) && key_eq));
	assign hit_now  = cmp_v_s1 && fn_lookup && cur_valid && id_eq && key_eq && !hit_q;
	assign free_now = cmp_v_s1 && fn_reg && (!cur_valid || (id_eq && key_eq)) && !free_q;

	assign claim   = cmd.exec && fn_reg && free_q;
	assign load_ok = last_ok_q && valid_q[last_q];
	assign sel_ix  = hit_haz_q ? item_q.hazard_index : item_q.segment_index;

	assign ent_we    = claim;
	assign ent_wdata = '{owner: item_q.owner_id, key: item_q.code_key,
		by_hazard: (item_q.entry_type == 8'd0)};

	assign slot_we    = cmd.clr_step || (cmd.exec && fn_load && load_ok);
	assign slot_waddr = cmd.clr_step ? clr_cnt_q : {last_q, slot_wrap(item_q.slot_index)};
	assign slot_wdata = cmd.clr_step ? slot_t'('0) :
		slot_t'{code: item_q.slot_code, volume: item_q.slot_volume};
	assign slot_raddr = {hit_idx_q, slot_wrap(sel_ix[2:0])};

	kst_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (free_idx_q),
		.wdata (ent_wdata),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (ent_rdata)
	);

	kst_ram #(.WIDTH($bits(slot_t)), .DEPTH(1 << SAW)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_comb begin
		res_d = '0;
		if (fn_lookup) begin
			res_d.matched = hit_q;
			if (!hit_q) begin
				res_d.result_code = 17'({5'd0, item_q.code_key[11:0]});
			end else if (sel_ix[3]) begin
				res_d.result_code = '1;
			end else begin
				res_d.result_code  = 17'({1'b0, slot_rdata.code});
				res_d.noise_volume = slot_rdata.volume;
			end
		end else if (fn_reg) begin
			res_d.status = free_q ? kst_pkg::ST_OK : kst_pkg::ST_FULL;
		end else if (fn_load) begin
			res_d.status = load_ok ? kst_pkg::ST_OK : kst_pkg::ST_NO_LAST;
		end
	end

	// Occupancy is taken when the result is pushed, after the operation has
	// settled the valid bits.
	always_comb begin
		out_d                = res_q;
		out_d.any_registered = (cnt_q != '0);
	end

	assign sts.clr_last  = &clr_cnt_q;
	assign sts.scan_done = (rd_cnt_q == CW'(ENTRIES)) && !cmp_v_s1;
	assign sts.is_lookup = fn_lookup;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_cnt_q    <= '0;
			cmp_v_s1    <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			last_q      <= '0;
			last_ok_q   <= 1'b0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.load) begin
				rd_cnt_q <= '0;
				cmp_v_s1 <= 1'b0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				cmp_v_s1 <= issue;
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (free_now) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.exec && fn_clear) begin
				valid_q <= '0;
				cnt_q   <= '0;
			end else if (drop) begin
				valid_q[cmp_idx_s1] <= 1'b0;
				cnt_q               <= cnt_q - 1'b1;
			end else if (claim) begin
				valid_q[free_idx_q] <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
			end
			if (cmd.exec && fn_reg) begin
				last_ok_q <= free_q;
				if (free_q) begin
					last_q <= free_idx_q;
				end
			end
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req_data;
		end
		cmp_idx_s1 <= rd_cnt_q[IW-1:0];
		if (hit_now) begin
			hit_idx_q <= cmp_idx_s1;
			hit_haz_q <= ent_rdata.by_hazard;
		end
		if (free_now) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
		if (cmd.push) begin
			rsp_q <= out_d;
		end
	end

endmodule
